/* rtl/qejsd_pkg.sv */
// Shared types, constants and arithmetic helpers for the quad element Jacobian block.
// Used by the controller, the datapath, the divider and the top level.
// No dependencies.
package qejsd_pkg;

	localparam int NODES       = 4;
	localparam int DIMS        = 2;
	localparam int BEND_POINTS = 4;

	localparam int COORD_W = 32;
	localparam int GAUSS_W = 17;
	localparam int TAB_W   = 18;
	localparam int PROD_W  = 64;
	localparam int ACC_W   = 66;
	localparam int NUM_W   = 51;
	localparam int DEN_W   = 31;

	localparam logic [GAUSS_W-1:0] GAUSS_RESET = 17'd37838;

	// point indexes
	localparam logic [2:0] PT_CENTER    = 3'd4;
	localparam logic [2:0] PT_LAST_MASS = 3'd3;
	localparam logic [2:0] PT_LAST_FULL = 3'd4;

	// Jacobian entry slots
	localparam logic [1:0] JAC_XR = 2'd0;
	localparam logic [1:0] JAC_XS = 2'd1;
	localparam logic [1:0] JAC_YR = 2'd2;
	localparam logic [1:0] JAC_YS = 2'd3;

	localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;
	localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

	typedef enum logic [3:0] {
		DP_NOP,
		DP_JMUL,
		DP_DMUL0,
		DP_DMUL1,
		DP_NMUL0,
		DP_NMUL1,
		DP_ACC,
		DP_SUB,
		DP_JSTORE,
		DP_DET,
		DP_DSTART,
		DP_DSTORE
	} dp_op_t;

	typedef struct packed {
		dp_op_t     op;
		logic       first;
		logic [3:0] idx;
		logic [2:0] k;
		logic       load;
		logic       emit;
		logic       last;
	} cmd_t;

	typedef struct packed {
		logic mass;
		logic inv;
		logic div_busy;
	} status_t;

	// Local shape derivative of node n at point k; d=0 for d/dr, d=1 for d/ds.
	function automatic logic signed [TAB_W-1:0] tab_entry(input logic [2:0] k,
		input logic d, input logic [1:0] n, input logic [GAUSS_W-1:0] g);
		logic nr, ns, pr, ps, sgn_node, sgn_term;
		logic signed [18:0] g19, t, v;
		nr = (n == 2'd0) || (n == 2'd3);
		ns = (n == 2'd0) || (n == 2'd1);
		pr = (k == 3'd0) || (k == 3'd3);
		ps = (k == 3'd0) || (k == 3'd1);
		if (!d) begin
			sgn_node = nr;
			sgn_term = ns ^ ps;
		end else begin
			sgn_node = ns;
			sgn_term = nr ^ pr;
		end
		g19 = signed'({2'b00, g});
		if (k == PT_CENTER) begin
			t = 19'sd65536;
		end else if (sgn_term) begin
			t = 19'sd65536 - g19;
		end else begin
			t = 19'sd65536 + g19;
		end
		v = sgn_node ? -t : t;
		return TAB_W'(v / 19'sd4);
	endfunction

	// Round Q32.32 to Q16.16 (half up) and saturate.
	function automatic logic signed [31:0] sat_round(input logic signed [ACC_W-1:0] a);
		logic signed [ACC_W-1:0] t, r;
		t = a + ACC_W'(32768);
		r = t >>> 16;
		if (r > ACC_W'(Q_MAX)) begin
			return Q_MAX;
		end else if (r < ACC_W'(Q_MIN)) begin
			return Q_MIN;
		end
		return r[31:0];
	endfunction

	function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
		input logic signed [31:0] b);
		logic signed [32:0] s;
		s = 33'(a) + 33'(b);
		if (s > 33'(Q_MAX)) begin
			return Q_MAX;
		end else if (s < 33'(Q_MIN)) begin
			return Q_MIN;
		end
		return s[31:0];
	endfunction

endpackage

/* rtl/qejsd_div.sv */
// Restoring divider, one quotient bit per cycle, with signed Q16.16 saturation.
// Depends on qejsd_pkg.
module qejsd_div import qejsd_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic                    num_neg,
	input  logic [NUM_W-1:0]        num_mag,
	input  logic [DEN_W-1:0]        den,
	output logic                    busy,
	output logic signed [31:0]      quot
);

	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic             neg_q;
	logic [5:0]       cnt_q;
	logic             busy_q;
	logic [DEN_W:0]   trial;
	logic [NUM_W-1:0] quo_neg;

	assign trial   = {rem_q, quo_q[NUM_W-1]};
	assign busy    = busy_q;
	assign quo_neg = -quo_q;

	// control: count the quotient bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 6'(NUM_W);
		end else if (busy_q) begin
			cnt_q  <= cnt_q - 6'd1;
			busy_q <= (cnt_q != 6'd1);
		end
	end

	// shift one dividend bit in, subtract when it fits
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num_mag;
			rem_q <= '0;
			den_q <= den;
			neg_q <= num_neg;
		end else if (busy_q) begin
			if (trial >= {1'b0, den_q}) begin
				rem_q <= DEN_W'(trial - {1'b0, den_q});
				quo_q <= {quo_q[NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[DEN_W-1:0];
				quo_q <= {quo_q[NUM_W-2:0], 1'b0};
			end
		end
	end

	// apply sign, saturate
	always_comb begin
		if (!neg_q) begin
			quot = (quo_q > NUM_W'(Q_MAX)) ? Q_MAX : signed'(quo_q[31:0]);
		end else begin
			quot = (quo_q > NUM_W'(64'h8000_0000)) ? Q_MIN : signed'(quo_neg[31:0]);
		end
	end

endmodule

/* rtl/qejsd_dpath.sv */
// Datapath: corner registers, shared multiplier, accumulator, Jacobian, determinant,
// area sum, derivative registers and the output register. Depends on qejsd_pkg, qejsd_div.
module qejsd_dpath import qejsd_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  cmd_t                      cmd,
	output status_t                   st,
	input  logic                      cfg_we,
	input  logic [GAUSS_W-1:0]        cfg_wdata,
	input  logic                      op,
	input  logic signed [COORD_W-1:0] x_node0,
	input  logic signed [COORD_W-1:0] x_node1,
	input  logic signed [COORD_W-1:0] x_node2,
	input  logic signed [COORD_W-1:0] x_node3,
	input  logic signed [COORD_W-1:0] y_node0,
	input  logic signed [COORD_W-1:0] y_node1,
	input  logic signed [COORD_W-1:0] y_node2,
	input  logic signed [COORD_W-1:0] y_node3,
	output logic signed [31:0]        jac_det,
	output logic signed [31:0]        dndx_0,
	output logic signed [31:0]        dndx_1,
	output logic signed [31:0]        dndx_2,
	output logic signed [31:0]        dndx_3,
	output logic signed [31:0]        dndy_0,
	output logic signed [31:0]        dndy_1,
	output logic signed [31:0]        dndy_2,
	output logic signed [31:0]        dndy_3,
	output logic signed [31:0]        area_sum,
	output logic                      inverted,
	output logic                      last
);

	logic [GAUSS_W-1:0]        gauss_q;
	logic signed [31:0]        x_q [NODES];
	logic signed [31:0]        y_q [NODES];
	logic                      mass_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic signed [31:0]        jac_q [4];
	logic signed [31:0]        det_q;
	logic                      inv_q;
	logic signed [31:0]        area_q;
	logic signed [31:0]        deriv_q [NODES*DIMS];
	logic signed [31:0]        mul_a, mul_b;
	logic signed [31:0]        det_next;
	logic signed [ACC_W-1:0]   acc_abs;
	logic signed [31:0]        quot;
	logic                      div_busy;
	logic                      show;

	assign st.mass     = mass_q;
	assign st.inv      = inv_q;
	assign st.div_busy = div_busy;

	// point coordinate register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gauss_q <= GAUSS_RESET;
		end else if (cfg_we) begin
			gauss_q <= cfg_wdata;
		end
	end

	// multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			DP_JMUL: begin
				mul_a = 32'(tab_entry(cmd.k, cmd.idx[2], cmd.idx[1:0], gauss_q));
				mul_b = cmd.idx[3] ? y_q[cmd.idx[1:0]] : x_q[cmd.idx[1:0]];
			end
			DP_DMUL0: begin
				mul_a = jac_q[JAC_XR];
				mul_b = jac_q[JAC_YS];
			end
			DP_DMUL1: begin
				mul_a = jac_q[JAC_YR];
				mul_b = jac_q[JAC_XS];
			end
			DP_NMUL0: begin
				mul_a = 32'(tab_entry(cmd.k, cmd.idx[2], cmd.idx[1:0], gauss_q));
				mul_b = cmd.idx[2] ? jac_q[JAC_XR] : jac_q[JAC_YS];
			end
			DP_NMUL1: begin
				mul_a = 32'(tab_entry(cmd.k, !cmd.idx[2], cmd.idx[1:0], gauss_q));
				mul_b = cmd.idx[2] ? jac_q[JAC_XS] : jac_q[JAC_YR];
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign det_next = sat_round(acc_q);
	assign acc_abs  = acc_q[ACC_W-1] ? -acc_q : acc_q;
	assign show     = !mass_q && !inv_q;

	qejsd_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.op == DP_DSTART),
		.num_neg (acc_q[ACC_W-1]),
		.num_mag (acc_abs[NUM_W-1:0]),
		.den     (det_q[DEN_W-1:0]),
		.busy    (div_busy),
		.quot    (quot)
	);

	// element registers and arithmetic steps
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mass_q <= op;
			area_q <= '0;
			x_q[0] <= x_node0;
			x_q[1] <= x_node1;
			x_q[2] <= x_node2;
			x_q[3] <= x_node3;
			y_q[0] <= y_node0;
			y_q[1] <= y_node1;
			y_q[2] <= y_node2;
			y_q[3] <= y_node3;
		end
		case (cmd.op)
			DP_JMUL, DP_DMUL0, DP_DMUL1, DP_NMUL0, DP_NMUL1: begin
				prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
			end
			DP_ACC: begin
				acc_q <= (cmd.first ? ACC_W'(0) : acc_q) + ACC_W'(prod_q);
			end
			DP_SUB: begin
				acc_q <= acc_q - ACC_W'(prod_q);
			end
			DP_JSTORE: begin
				jac_q[cmd.idx[3:2]] <= det_next;
			end
			DP_DET: begin
				det_q <= det_next;
				inv_q <= (det_next <= 32'sd0);
				if (cmd.k != PT_CENTER) begin
					area_q <= sat_add(area_q, det_next);
				end
			end
			DP_DSTORE: begin
				deriv_q[cmd.idx[2:0]] <= quot;
			end
			default: begin
			end
		endcase
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			jac_det  <= det_q;
			dndx_0   <= show ? deriv_q[0] : '0;
			dndx_1   <= show ? deriv_q[1] : '0;
			dndx_2   <= show ? deriv_q[2] : '0;
			dndx_3   <= show ? deriv_q[3] : '0;
			dndy_0   <= show ? deriv_q[4] : '0;
			dndy_1   <= show ? deriv_q[5] : '0;
			dndy_2   <= show ? deriv_q[6] : '0;
			dndy_3   <= show ? deriv_q[7] : '0;
			area_sum <= area_q;
			inverted <= inv_q;
			last     <= cmd.last;
		end
	end

endmodule

/* rtl/qejsd_ctrl.sv */
// Controller: sequences the points, the Jacobian sums, the determinant and the
// derivative divisions, and owns both handshakes. Depends on qejsd_pkg.
module qejsd_ctrl import qejsd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	output logic    out_valid,
	input  logic    out_stall,
	input  status_t st,
	output cmd_t    cmd
);

	typedef enum logic [4:0] {
		ST_IDLE, ST_JMUL, ST_JACC, ST_JST, ST_DMUL0, ST_DACC, ST_DMUL1, ST_DSUB,
		ST_DET, ST_BRANCH, ST_NMUL0, ST_NACC, ST_NMUL1, ST_NSUB, ST_DSTART,
		ST_DWAIT, ST_DSTORE, ST_EMIT
	} state_t;

	state_t     state_q, state_d;
	logic [3:0] cnt_q, cnt_d;
	logic [2:0] k_q, k_d;
	logic       out_valid_q;
	dp_op_t     op_q, op_d;
	logic       first_q, first_d;
	logic       accept, slot_free, emit, last_pt;

	assign accept    = in_valid && (state_q == ST_IDLE);
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign slot_free = !out_valid_q || !out_stall;
	assign emit      = (state_q == ST_EMIT) && slot_free;
	assign last_pt   = st.inv || (k_q == (st.mass ? PT_LAST_MASS : PT_LAST_FULL));

	assign cmd.op    = op_q;
	assign cmd.first = first_q;
	assign cmd.idx   = cnt_q;
	assign cmd.k     = k_q;
	assign cmd.load  = accept;
	assign cmd.emit  = emit;
	assign cmd.last  = last_pt;

	// next state
	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		k_d     = k_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_JMUL;
					cnt_d   = '0;
					k_d     = '0;
				end
			end
			ST_JMUL:  state_d = ST_JACC;
			ST_JACC: begin
				if (cnt_q[1:0] == 2'd3) begin
					state_d = ST_JST;
				end else begin
					state_d = ST_JMUL;
					cnt_d   = cnt_q + 4'd1;
				end
			end
			ST_JST: begin
				if (cnt_q == 4'd15) begin
					state_d = ST_DMUL0;
				end else begin
					state_d = ST_JMUL;
					cnt_d   = cnt_q + 4'd1;
				end
			end
			ST_DMUL0:  state_d = ST_DACC;
			ST_DACC:   state_d = ST_DMUL1;
			ST_DMUL1:  state_d = ST_DSUB;
			ST_DSUB:   state_d = ST_DET;
			ST_DET:    state_d = ST_BRANCH;
			ST_BRANCH: begin
				if (st.mass || st.inv) begin
					state_d = ST_EMIT;
				end else begin
					state_d = ST_NMUL0;
					cnt_d   = '0;
				end
			end
			ST_NMUL0:  state_d = ST_NACC;
			ST_NACC:   state_d = ST_NMUL1;
			ST_NMUL1:  state_d = ST_NSUB;
			ST_NSUB:   state_d = ST_DSTART;
			ST_DSTART: state_d = ST_DWAIT;
			ST_DWAIT: begin
				if (!st.div_busy) begin
					state_d = ST_DSTORE;
				end
			end
			ST_DSTORE: begin
				if (cnt_q[2:0] == 3'd7) begin
					state_d = ST_EMIT;
				end else begin
					state_d = ST_NMUL0;
					cnt_d   = cnt_q + 4'd1;
				end
			end
			ST_EMIT: begin
				if (slot_free) begin
					if (last_pt) begin
						state_d = ST_IDLE;
					end else begin
						state_d = ST_JMUL;
						cnt_d   = '0;
						k_d     = k_q + 3'd1;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// datapath command for the coming state
	always_comb begin
		first_d = 1'b0;
		case (state_d)
			ST_JMUL:            op_d = DP_JMUL;
			ST_JACC: begin
				op_d    = DP_ACC;
				first_d = (cnt_d[1:0] == 2'd0);
			end
			ST_DACC, ST_NACC: begin
				op_d    = DP_ACC;
				first_d = 1'b1;
			end
			ST_JST:             op_d = DP_JSTORE;
			ST_DMUL0:           op_d = DP_DMUL0;
			ST_DMUL1:           op_d = DP_DMUL1;
			ST_DSUB, ST_NSUB:   op_d = DP_SUB;
			ST_DET:             op_d = DP_DET;
			ST_NMUL0:           op_d = DP_NMUL0;
			ST_NMUL1:           op_d = DP_NMUL1;
			ST_DSTART:          op_d = DP_DSTART;
			ST_DSTORE:          op_d = DP_DSTORE;
			default:            op_d = DP_NOP;
		endcase
	end

	// hold state, counters, command and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			k_q         <= '0;
			op_q        <= DP_NOP;
			first_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			k_q     <= k_d;
			op_q    <= op_d;
			first_q <= first_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_JMUL) && (k_q == 3'd0))
		else $error("accepted item did not start at the first point");
	a_point_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> (k_q <= PT_CENTER))
		else $error("point index out of range");
	a_no_emit_dividing: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> !st.div_busy)
		else $error("result emitted while divider busy");
	a_div_store: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DWAIT) && !st.div_busy |=> (state_q == ST_DSTORE))
		else $error("divider result not stored");
`endif

endmodule

/* rtl/quad_element_jacobian_shape_derivs.sv */
// Top level of the 4-node quadrilateral Jacobian and shape derivative block.
// Depends on qejsd_pkg, qejsd_ctrl, qejsd_dpath (and qejsd_div below it).
//
//   channel | handshake              | payload
//   cfg     | cfg_we                 | cfg_wdata (gauss_coord)
//   in      | in_valid / in_stall    | op, x_node0..3, y_node0..3
//   out     | out_valid / out_stall  | jac_det, dndx_*, dndy_*, area_sum, inverted, last
//
// One element at a time. Each point computes the Jacobian and determinant, then in full mode
// 8 derivatives, each through the 51-step divider; mass mode and an inverted point stop after
// the determinant.
// Reset is asynchronous, active low; gauss_coord returns to 37838.
// A stalled result holds the sequencer only at the next emit.
module quad_element_jacobian_shape_derivs import qejsd_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [GAUSS_W-1:0]        cfg_wdata,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      op,
	input  logic signed [COORD_W-1:0] x_node0,
	input  logic signed [COORD_W-1:0] x_node1,
	input  logic signed [COORD_W-1:0] x_node2,
	input  logic signed [COORD_W-1:0] x_node3,
	input  logic signed [COORD_W-1:0] y_node0,
	input  logic signed [COORD_W-1:0] y_node1,
	input  logic signed [COORD_W-1:0] y_node2,
	input  logic signed [COORD_W-1:0] y_node3,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [31:0]        jac_det,
	output logic signed [31:0]        dndx_0,
	output logic signed [31:0]        dndx_1,
	output logic signed [31:0]        dndx_2,
	output logic signed [31:0]        dndx_3,
	output logic signed [31:0]        dndy_0,
	output logic signed [31:0]        dndy_1,
	output logic signed [31:0]        dndy_2,
	output logic signed [31:0]        dndy_3,
	output logic signed [31:0]        area_sum,
	output logic                      inverted,
	output logic                      last
);

	cmd_t    cmd;
	status_t st;

	qejsd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.st        (st),
		.cmd       (cmd)
	);

	qejsd_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.op        (op),
		.x_node0   (x_node0),
		.x_node1   (x_node1),
		.x_node2   (x_node2),
		.x_node3   (x_node3),
		.y_node0   (y_node0),
		.y_node1   (y_node1),
		.y_node2   (y_node2),
		.y_node3   (y_node3),
		.jac_det   (jac_det),
		.dndx_0    (dndx_0),
		.dndx_1    (dndx_1),
		.dndx_2    (dndx_2),
		.dndx_3    (dndx_3),
		.dndy_0    (dndy_0),
		.dndy_1    (dndy_1),
		.dndy_2    (dndy_2),
		.dndy_3    (dndy_3),
		.area_sum  (area_sum),
		.inverted  (inverted),
		.last      (last)
	);

endmodule

/* sim/testbench.sv */
// Testbench for quad_element_jacobian_shape_derivs: random and directed quad elements,
// checked point by point against an in-bench Jacobian and shape derivative predictor.
// Depends on qejsd_pkg and the RTL top level.
module testbench import qejsd_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic signed [31:0] det;
		logic signed [31:0] dx0, dx1, dx2, dx3;
		logic signed [31:0] dy0, dy1, dy2, dy3;
		logic signed [31:0] area;
		logic inv;
		logic lst;
	} point_t;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [GAUSS_W-1:0] cfg_wdata = '0;
	logic in_valid = 0;
	logic in_stall;
	logic op = 0;
	logic signed [31:0] x_node0 = 0, x_node1 = 0, x_node2 = 0, x_node3 = 0;
	logic signed [31:0] y_node0 = 0, y_node1 = 0, y_node2 = 0, y_node3 = 0;
	logic out_valid;
	logic out_stall = 0;
	logic signed [31:0] jac_det, dndx_0, dndx_1, dndx_2, dndx_3;
	logic signed [31:0] dndy_0, dndy_1, dndy_2, dndy_3, area_sum;
	logic inverted, last;

	point_t expected_points[$];
	longint shape_dr[5][4], shape_ds[5][4];
	int error_count = 0;
	bit hold_off = 0;

	quad_element_jacobian_shape_derivs dut (.*);

	always #5 clk = ~clk;

	// rebuild the local derivative table for a gauss coordinate
	function automatic void load_shape_table(input longint g);
		int sr[4] = '{-1, 1, 1, -1};
		int ss[4] = '{-1, -1, 1, 1};
		int pr[5] = '{-1, 1, 1, -1, 0};
		int ps[5] = '{-1, -1, 1, 1, 0};
		for (int k = 0; k < 5; k++)
			for (int n = 0; n < 4; n++) begin
				shape_dr[k][n] = (sr[n] * (64'sd65536 + ss[n] * ps[k] * g)) / 4;
				shape_ds[k][n] = (ss[n] * (64'sd65536 + sr[n] * pr[k] * g)) / 4;
			end
	endfunction

	function automatic longint clamp32(input longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// floor((v + half) / 2^16), no overflow for these ranges
	function automatic longint round_q16(input longint v);
		return (v + 32768) >>> 16;
	endfunction

	// predict all points of one element
	task automatic predict_element(input logic m, input longint xs[4], input longint ys[4]);
		longint axr, axs, ayr, ays, xr, xsd, yr, ysd, det, area, nx, ny;
		point_t p;
		int npts;
		area = 0;
		npts = m ? 4 : 5;
		for (int k = 0; k < npts; k++) begin
			axr = 0; axs = 0; ayr = 0; ays = 0;
			for (int n = 0; n < 4; n++) begin
				axr += shape_dr[k][n] * xs[n];
				axs += shape_ds[k][n] * xs[n];
				ayr += shape_dr[k][n] * ys[n];
				ays += shape_ds[k][n] * ys[n];
			end
			xr = clamp32(round_q16(axr)); xsd = clamp32(round_q16(axs));
			yr = clamp32(round_q16(ayr)); ysd = clamp32(round_q16(ays));
			// product difference stays inside 64 bits for saturated entries
			det = clamp32(round_q16(xr * ysd - yr * xsd));
			if (k < 4) area = clamp32(area + det);
			p = '0;
			p.det = 32'(det);
			p.inv = det <= 0;
			p.lst = p.inv || k == npts - 1;
			p.area = 32'(area);
			if (!m && !p.inv) begin
				longint rx[4], ry[4];
				for (int n = 0; n < 4; n++) begin
					nx = shape_dr[k][n] * ysd - shape_ds[k][n] * yr;
					ny = shape_ds[k][n] * xr - shape_dr[k][n] * xsd;
					rx[n] = clamp32(nx / det);
					ry[n] = clamp32(ny / det);
				end
				p.dx0 = 32'(rx[0]); p.dx1 = 32'(rx[1]); p.dx2 = 32'(rx[2]); p.dx3 = 32'(rx[3]);
				p.dy0 = 32'(ry[0]); p.dy1 = 32'(ry[1]); p.dy2 = 32'(ry[2]); p.dy3 = 32'(ry[3]);
			end
			expected_points.push_back(p);
			if (p.inv) break;
		end
	endtask

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d want %0d", what, got, want);
		error_count++;
	endtask

	// drive one element; gap drawn before it, valid held low over the gap
	task automatic send_element(input logic m, input longint xs[4], input longint ys[4]);
		int gap;
		gap = $urandom_range(0, 15);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		predict_element(m, xs, ys);
		op <= m;
		x_node0 <= 32'(xs[0]); x_node1 <= 32'(xs[1]);
		x_node2 <= 32'(xs[2]); x_node3 <= 32'(xs[3]);
		y_node0 <= 32'(ys[0]); y_node1 <= 32'(ys[1]);
		y_node2 <= 32'(ys[2]); y_node3 <= 32'(ys[3]);
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
	endtask

	// drop valid and wait for every expected point
	task automatic drain;
		in_valid <= 1'b0;
		while (expected_points.size() != 0) @(posedge clk);
		repeat (600) @(posedge clk);
	endtask

	task automatic write_gauss(input logic [GAUSS_W-1:0] g);
		cfg_wdata <= g;
		cfg_we <= 1;
		@(posedge clk);
		cfg_we <= 0;
		load_shape_table(g);
	endtask

	function automatic longint rand_coord(input int mode);
		case (mode)
			0: return $signed($urandom());
			1: return longint'($urandom_range(0, 20)) * 65536 - 10 * 65536;
			default: return $signed($urandom()) >>> $urandom_range(4, 24);
		endcase
	endfunction

	// unit square corners scaled, optionally swapped to invert
	task automatic send_square(input logic m, input longint scale, input bit flip);
		longint xs[4], ys[4];
		xs = '{-scale, scale, scale, -scale};
		ys = '{-scale, -scale, scale, scale};
		if (flip) ys = '{scale, scale, -scale, -scale};
		send_element(m, xs, ys);
	endtask

	task automatic test_directed;
		longint xs[4], ys[4];
		send_square(1'b0, 65536, 1'b0);
		send_square(1'b1, 65536, 1'b0);
		send_square(1'b0, 65536, 1'b1);
		send_square(1'b1, 65536, 1'b1);
		send_square(1'b0, 64'sd2147483647, 1'b0);
		send_square(1'b1, 64'sd1073741824, 1'b0);
		send_square(1'b0, 1, 1'b0);
		xs = '{-64'sd2147483648, 64'sd2147483647, 64'sd2147483647, -64'sd2147483648};
		ys = '{-64'sd2147483648, -64'sd2147483648, 64'sd2147483647, 64'sd2147483647};
		send_element(1'b0, xs, ys);
		send_element(1'b1, xs, ys);
		xs = '{0, 0, 0, 0}; ys = '{0, 0, 0, 0};
		send_element(1'b0, xs, ys);
		xs = '{-1, -1, -1, -1}; ys = '{-1, -1, -1, -1};
		send_element(1'b1, xs, ys);
		// skewed element that folds past the centre
		xs = '{0, 4 * 65536, 65536, 3 * 65536}; ys = '{0, 0, 4 * 65536, 65536};
		send_element(1'b0, xs, ys);
		drain();
	endtask

	task automatic test_random(input int count);
		longint xs[4], ys[4];
		int mode;
		for (int i = 0; i < count; i++) begin
			mode = $urandom_range(0, 3);
			if (mode == 3) begin
				// square quad of random half-size with jitter on each corner
				longint s;
				s = longint'($urandom_range(1, 1 << 20));
				xs = '{-s, s, s, -s}; ys = '{-s, -s, s, s};
				for (int n = 0; n < 4; n++) begin
					xs[n] += $signed($urandom()) >>> 14;
					ys[n] += $signed($urandom()) >>> 14;
				end
			end else
				for (int n = 0; n < 4; n++) begin
					xs[n] = rand_coord(mode);
					ys[n] = rand_coord(mode);
				end
			send_element(1'($urandom_range(0, 1)), xs, ys);
		end
	endtask

	task automatic test_backpressure;
		hold_off = 1;
		for (int i = 0; i < 3; i++) send_square(1'(i % 2), 65536 * (i + 1), 1'b0);
		drain();
	endtask

	task automatic test_gauss_settings;
		write_gauss(0);
		test_random(20);
		drain();
		write_gauss(17'd65536);
		test_random(20);
		drain();
		write_gauss(17'h1ffff);
		test_random(15);
		drain();
		write_gauss(GAUSS_W'($urandom_range(0, 17'h1ffff)));
		test_random(20);
		drain();
		write_gauss(GAUSS_RESET);
	endtask

	// receiver stall: random wait per item, or a long hold when requested
	initial begin
		int wait_cycles;
		forever begin
			if (hold_off) begin
				out_stall <= 1;
				repeat (4000) @(posedge clk);
				hold_off = 0;
			end else begin
				wait_cycles = $urandom_range(0, 15);
				if (wait_cycles != 0) begin
					out_stall <= 1;
					repeat (wait_cycles) @(posedge clk);
				end
				out_stall <= 0;
				@(posedge clk);
			end
		end
	end

	// compare each accepted point with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_points.size() == 0) begin
				report_mismatch("unexpected point", jac_det, 0);
			end else begin
				point_t e;
				e = expected_points.pop_front();
				if (jac_det !== e.det) report_mismatch("jac_det", jac_det, e.det);
				if (dndx_0 !== e.dx0) report_mismatch("dndx_0", dndx_0, e.dx0);
				if (dndx_1 !== e.dx1) report_mismatch("dndx_1", dndx_1, e.dx1);
				if (dndx_2 !== e.dx2) report_mismatch("dndx_2", dndx_2, e.dx2);
				if (dndx_3 !== e.dx3) report_mismatch("dndx_3", dndx_3, e.dx3);
				if (dndy_0 !== e.dy0) report_mismatch("dndy_0", dndy_0, e.dy0);
				if (dndy_1 !== e.dy1) report_mismatch("dndy_1", dndy_1, e.dy1);
				if (dndy_2 !== e.dy2) report_mismatch("dndy_2", dndy_2, e.dy2);
				if (dndy_3 !== e.dy3) report_mismatch("dndy_3", dndy_3, e.dy3);
				if (area_sum !== e.area) report_mismatch("area_sum", area_sum, e.area);
				if (inverted !== e.inv) report_mismatch("inverted", inverted, e.inv);
				if (last !== e.lst) report_mismatch("last", last, e.lst);
			end
		end
	end

	initial begin
		#400ms;
		$display("testbench: done, errors");
		$finish;
	end

	initial begin
		load_shape_table(GAUSS_RESET);
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed();
		test_backpressure();
		test_random(200);
		drain();
		test_gauss_settings();
		drain();
		if (error_count == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
